/* src/prt_pkg.sv */
// Shared types and constants for the presence reminder timer.
// Used by the divider, datapath, controller and top level.
package prt_pkg;

  localparam int unsigned TimeBits  = 32;
  localparam int unsigned CfgDataW  = 32;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned ShortW    = 16;
  localparam int unsigned LevelW    = 8;
  localparam int unsigned NumerW    = ShortW + LevelW;
  localparam int unsigned DivSteps  = TimeBits;
  localparam int unsigned DivCntW   = $clog2(DivSteps);

  localparam logic [TimeBits-1:0] ReminderReset = TimeBits'(20 * 60 * 1000);
  localparam logic [TimeBits-1:0] AwayReset     = TimeBits'(4 * 60 * 1000);
  localparam logic [ShortW-1:0]   DebounceReset = ShortW'(200);
  localparam logic [ShortW-1:0]   FadeReset     = ShortW'(2500);
  localparam logic [LevelW-1:0]   FadeBright    = LevelW'(120);
  localparam logic [LevelW-1:0]   FullBright    = LevelW'(255);
  localparam logic [ShortW-1:0]   FadeMin       = ShortW'(2);

  typedef enum logic [CfgIdxW-1:0] {
    CfgReminder = 2'd0,
    CfgAway     = 2'd1,
    CfgDebounce = 2'd2,
    CfgFade     = 2'd3
  } cfg_reg_e;

  typedef enum logic [10:0] {
    S_IDLE   = 11'b000_0000_0001,
    S_MOTION = 11'b000_0000_0010,
    S_CLEAR  = 11'b000_0000_0100,
    S_MACRO  = 11'b000_0000_1000,
    S_AWAY   = 11'b000_0001_0000,
    S_MOD    = 11'b000_0010_0000,
    S_MODW   = 11'b000_0100_0000,
    S_PREP   = 11'b000_1000_0000,
    S_SCALE  = 11'b001_0000_0000,
    S_SCALEW = 11'b010_0000_0000,
    S_WB     = 11'b100_0000_0000
  } state_e;

  typedef struct packed {
    logic capture;
    logic motion;
    logic clear;
    logic macro;
    logic away;
    logic div_start;
    logic div_sel;
    logic prep;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic show;
    logic fade_ok;
    logic div_done;
    logic out_free;
  } status_t;

endpackage

/* src/prt_div.sv */
// Restoring divider, one quotient bit per cycle, for the fade phase and scale.
// Depends on prt_pkg for widths.
module prt_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [prt_pkg::TimeBits-1:0]   dividend_i,
  input  logic [prt_pkg::ShortW-1:0]     divisor_i,
  output logic [prt_pkg::TimeBits-1:0]   quotient_o,
  output logic [prt_pkg::ShortW-1:0]     remainder_o,
  output logic                           done_o
);
  import prt_pkg::*;

  logic                busy_q;
  logic                done_q;
  logic [DivCntW-1:0]  cnt_q;
  logic [TimeBits-1:0] quo_q;
  logic [ShortW-1:0]   rem_q;
  logic [ShortW-1:0]   dvs_q;
  logic [ShortW:0]     rem_sh;
  logic                ge;
  logic [ShortW:0]     rem_sub;

  assign rem_sh  = {rem_q, quo_q[TimeBits-1]};
  assign ge      = rem_sh >= {1'b0, dvs_q};
  assign rem_sub = rem_sh - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DivCntW'(DivSteps - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[TimeBits-2:0], ge};
      rem_q <= ge ? rem_sub[ShortW-1:0] : rem_sh[ShortW-1:0];
    end
  end

  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;
  assign done_o      = done_q;

endmodule

/* src/prt_datapath.sv */
// Datapath: configuration, presence and button state, fade arithmetic, result word.
// Depends on prt_pkg and prt_div.
module prt_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  prt_pkg::cmd_t                 cmd_i,
  output prt_pkg::status_t              status_o,
  input  logic                          cfg_we_i,
  input  logic [prt_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [prt_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic [prt_pkg::TimeBits-1:0]  now_ms_i,
  input  logic                          motion_edge_i,
  input  logic                          clear_low_i,
  input  logic                          clear_edge_i,
  input  logic                          macro_low_i,
  input  logic                          macro_edge_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [prt_pkg::LevelW-1:0]    green_level_o,
  output logic [prt_pkg::LevelW-1:0]    pixel_brightness_o,
  output logic                          send_macro_o,
  output logic                          timer_armed_o
);
  import prt_pkg::*;

  logic [TimeBits-1:0] reminder_q, away_q;
  logic [ShortW-1:0]   debounce_q, fade_q;
  logic [TimeBits-1:0] last_seen_q, last_motion_q, deadline_q;
  logic [TimeBits-1:0] last_clear_q, last_macro_q;
  logic                clear_prev_q, macro_prev_q, clear_pend_q, macro_pend_q;
  logic                out_valid_q;

  logic [TimeBits-1:0] now_q, elapsed_q;
  logic                motion_q, clear_low_q, macro_low_q;
  logic                send_q, show_q, lower_q;
  logic [NumerW-1:0]   numer_q;
  logic [LevelW-1:0]   green_q, bright_q;
  logic                send_out_q, armed_out_q;

  logic [TimeBits-1:0] arm_time;
  logic [TimeBits-1:0] since_motion, since_clear, since_macro, since_seen;
  logic                clear_hit, macro_hit, away_hit, due;
  logic [ShortW-1:0]   half;
  logic [ShortW-1:0]   phase, span;
  logic                phase_low;
  logic [TimeBits-1:0] div_dividend;
  logic [ShortW-1:0]   div_divisor;
  logic [TimeBits-1:0] div_quo;
  logic [ShortW-1:0]   div_rem;
  logic                div_done;
  logic                fade_ok;
  logic [LevelW-1:0]   green_d;

  assign arm_time     = now_q + reminder_q;
  assign since_motion = now_q - last_motion_q;
  assign since_clear  = now_q - last_clear_q;
  assign since_macro  = now_q - last_macro_q;
  assign since_seen   = now_q - last_seen_q;
  assign clear_hit    = (clear_pend_q || (clear_low_q && !clear_prev_q)) &&
                        (since_clear >= TimeBits'(debounce_q));
  assign macro_hit    = (macro_pend_q || (macro_low_q && !macro_prev_q)) &&
                        (since_macro >= TimeBits'(debounce_q));
  assign away_hit     = (last_seen_q != '0) && (since_seen > away_q);
  assign due          = (deadline_q != '0) && (now_q >= deadline_q);
  assign fade_ok      = fade_q >= FadeMin;
  assign half         = {1'b0, fade_q[ShortW-1:1]};
  assign phase        = div_rem;
  assign phase_low    = phase < half;
  assign span         = phase_low ? phase : phase - half;

  assign div_dividend = cmd_i.div_sel ? TimeBits'(numer_q) : elapsed_q;
  assign div_divisor  = cmd_i.div_sel ? half : fade_q;

  prt_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (cmd_i.div_start),
    .dividend_i  (div_dividend),
    .divisor_i   (div_divisor),
    .quotient_o  (div_quo),
    .remainder_o (div_rem),
    .done_o      (div_done)
  );

  always_comb begin
    green_d = '0;
    if (show_q && fade_ok) begin
      green_d = lower_q ? div_quo[LevelW-1:0] : FullBright - div_quo[LevelW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reminder_q    <= ReminderReset;
      away_q        <= AwayReset;
      debounce_q    <= DebounceReset;
      fade_q        <= FadeReset;
      last_seen_q   <= '0;
      last_motion_q <= '0;
      deadline_q    <= '0;
      last_clear_q  <= '0;
      last_macro_q  <= '0;
      clear_prev_q  <= 1'b0;
      macro_prev_q  <= 1'b0;
      clear_pend_q  <= 1'b0;
      macro_pend_q  <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          CfgReminder: reminder_q <= cfg_data_i[TimeBits-1:0];
          CfgAway:     away_q     <= cfg_data_i[TimeBits-1:0];
          CfgDebounce: debounce_q <= cfg_data_i[ShortW-1:0];
          CfgFade:     fade_q     <= cfg_data_i[ShortW-1:0];
          default:     ;
        endcase
      end
      if (cmd_i.capture) begin
        if (clear_edge_i) clear_pend_q <= 1'b1;
        if (macro_edge_i) macro_pend_q <= 1'b1;
      end
      if (cmd_i.motion && motion_q) begin
        last_seen_q   <= now_q;
        last_motion_q <= now_q;
        if (last_motion_q == '0 || since_motion > away_q) begin
          deadline_q <= arm_time;
        end
      end
      if (cmd_i.clear) begin
        clear_prev_q <= clear_low_q;
        if (clear_hit) begin
          clear_pend_q <= 1'b0;
          last_clear_q <= now_q;
          deadline_q   <= arm_time;
        end
      end
      if (cmd_i.macro) begin
        macro_prev_q <= macro_low_q;
        if (macro_hit) begin
          macro_pend_q <= 1'b0;
          last_macro_q <= now_q;
        end
      end
      if (cmd_i.away && away_hit) begin
        deadline_q <= '0;
      end
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      now_q       <= now_ms_i;
      motion_q    <= motion_edge_i;
      clear_low_q <= clear_low_i;
      macro_low_q <= macro_low_i;
      send_q      <= 1'b0;
    end
    if (cmd_i.macro && macro_hit) begin
      send_q <= 1'b1;
    end
    if (cmd_i.away) begin
      show_q    <= !away_hit && due;
      elapsed_q <= now_q - deadline_q;
    end
    if (cmd_i.prep) begin
      lower_q <= phase_low;
      numer_q <= NumerW'(span) * NumerW'(FullBright);
    end
    if (cmd_i.load_out) begin
      green_q     <= green_d;
      bright_q    <= show_q ? FadeBright : FullBright;
      send_out_q  <= send_q;
      armed_out_q <= deadline_q != '0;
    end
  end

  assign status_o.show     = show_q;
  assign status_o.fade_ok  = fade_ok;
  assign status_o.div_done = div_done;
  assign status_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o        = out_valid_q;
  assign green_level_o      = green_q;
  assign pixel_brightness_o = bright_q;
  assign send_macro_o       = send_out_q;
  assign timer_armed_o      = armed_out_q;

endmodule

/* src/prt_ctrl.sv */
// Controller: sequences a word: state update, modulo/scale if fading, write-back.
// Depends on prt_pkg.
module prt_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  prt_pkg::status_t   status_i,
  output prt_pkg::cmd_t      cmd_o
);
  import prt_pkg::*;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_MOTION;
        end
      end
      S_MOTION: begin
        cmd_o.motion = 1'b1;
        state_d      = S_CLEAR;
      end
      S_CLEAR: begin
        cmd_o.clear = 1'b1;
        state_d     = S_MACRO;
      end
      S_MACRO: begin
        cmd_o.macro = 1'b1;
        state_d     = S_AWAY;
      end
      S_AWAY: begin
        cmd_o.away = 1'b1;
        state_d    = S_MOD;
      end
      S_MOD: begin
        if (status_i.show && status_i.fade_ok) begin
          cmd_o.div_start = 1'b1;
          state_d         = S_MODW;
        end else begin
          state_d = S_WB;
        end
      end
      S_MODW: begin
        if (status_i.div_done) state_d = S_PREP;
      end
      S_PREP: begin
        cmd_o.prep = 1'b1;
        state_d    = S_SCALE;
      end
      S_SCALE: begin
        cmd_o.div_sel   = 1'b1;
        cmd_o.div_start = 1'b1;
        state_d         = S_SCALEW;
      end
      S_SCALEW: begin
        if (status_i.div_done) state_d = S_WB;
      end
      S_WB: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = state_q == S_IDLE;

endmodule

/* src/presence_reminder_timer.sv */
// Presence reminder timer: motion and button handling with a timed fade reminder.
// Top level; depends on prt_pkg, prt_ctrl and prt_datapath.
//
// Usage: one input word per millisecond pass arrives on in_valid_i/in_ready_o
// with the timestamp, motion event and both button levels and edges. Each
// word gives exactly one result word on out_valid_o/out_ready_i: green level,
// global brightness, send strobe and armed flag.
// Sequence: the word passes through the capture, motion, clear, macro and away
// updates to write-back when no fade is shown; with a fade, the shared
// restoring divider, producing one quotient bit per cycle, runs first for
// the phase modulo and then for the scale to 0..255. One word is in work at a
// time, so a new word is accepted only once the previous one is written back.
// A finished result sits in the output register; the next word is accepted
// while it waits, and its own result is held until the receiver takes the
// previous one. Configuration writes through cfg_we_i take effect at once
// and must happen while no word is in work.
// Reset loads the default register values and clears all timing state:
// nobody seen, no deadline, no pending presses, no result waiting.
module presence_reminder_timer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [prt_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [prt_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [prt_pkg::TimeBits-1:0]  now_ms_i,
  input  logic                          motion_edge_i,
  input  logic                          clear_low_i,
  input  logic                          clear_edge_i,
  input  logic                          macro_low_i,
  input  logic                          macro_edge_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [prt_pkg::LevelW-1:0]    green_level_o,
  output logic [prt_pkg::LevelW-1:0]    pixel_brightness_o,
  output logic                          send_macro_o,
  output logic                          timer_armed_o
);
  import prt_pkg::*;

  cmd_t    cmd;
  status_t status;

  prt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  prt_datapath u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .status_o           (status),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_data_i         (cfg_data_i),
    .now_ms_i           (now_ms_i),
    .motion_edge_i      (motion_edge_i),
    .clear_low_i        (clear_low_i),
    .clear_edge_i       (clear_edge_i),
    .macro_low_i        (macro_low_i),
    .macro_edge_i       (macro_edge_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .green_level_o      (green_level_o),
    .pixel_brightness_o (pixel_brightness_o),
    .send_macro_o       (send_macro_o),
    .timer_armed_o      (timer_armed_o)
  );

endmodule

/* dv/tb.sv */
// Self-checking bench for presence_reminder_timer: timestamped passes with random handshake
// gaps, every result word compared against a local model of the timer, fade and buttons.
// Depends on prt_pkg and the presence_reminder_timer RTL.
module tb;
  import prt_pkg::*;

  localparam int unsigned CycleLimit  = 2_000_000;
  localparam int unsigned DrainCycles = 80;

  typedef struct packed {
    logic [TimeBits-1:0] now;
    logic                motion;
    logic                clear_low;
    logic                clear_edge;
    logic                macro_low;
    logic                macro_edge;
  } pass_t;

  typedef struct packed {
    logic [LevelW-1:0] green;
    logic [LevelW-1:0] bright;
    logic              send;
    logic              armed;
  } light_t;

  logic                clk_i              = 1'b0;
  logic                rst_ni             = 1'b0;
  logic                cfg_we_i           = 1'b0;
  cfg_reg_e            cfg_idx_i          = CfgReminder;
  logic [CfgDataW-1:0] cfg_data_i         = '0;
  logic                in_valid_i         = 1'b0;
  logic                in_ready_o;
  logic [TimeBits-1:0] now_ms_i           = '0;
  logic                motion_edge_i      = 1'b0;
  logic                clear_low_i        = 1'b0;
  logic                clear_edge_i       = 1'b0;
  logic                macro_low_i        = 1'b0;
  logic                macro_edge_i       = 1'b0;
  logic                out_valid_o;
  logic                out_ready_i        = 1'b0;
  logic [LevelW-1:0]   green_level_o;
  logic [LevelW-1:0]   pixel_brightness_o;
  logic                send_macro_o;
  logic                timer_armed_o;

  presence_reminder_timer dut (.*);

  logic [TimeBits-1:0] interval_ms   = ReminderReset;
  logic [TimeBits-1:0] away_ms       = AwayReset;
  logic [ShortW-1:0]   press_gap_ms  = DebounceReset;
  logic [ShortW-1:0]   fade_ms       = FadeReset;
  logic [TimeBits-1:0] seen_at       = '0;
  logic [TimeBits-1:0] motion_at     = '0;
  logic [TimeBits-1:0] due_at        = '0;
  logic [TimeBits-1:0] clear_at      = '0;
  logic [TimeBits-1:0] macro_at      = '0;
  logic                clear_was_low = 1'b0;
  logic                macro_was_low = 1'b0;
  logic                clear_waiting = 1'b0;
  logic                macro_waiting = 1'b0;

  light_t              pending_lights[$];
  light_t              want_light;
  logic [TimeBits-1:0] desk_ms    = '0;
  logic                clear_held = 1'b0;
  logic                macro_held = 1'b0;
  logic                calm       = 1'b0;
  int unsigned         faults     = 0;
  int unsigned         cycles     = 0;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic logic [LevelW-1:0] fade_level(input logic [TimeBits-1:0] elapsed);
    logic [ShortW-1:0] half;
    logic [ShortW-1:0] phase;
    logic [31:0]       scaled;
    if (fade_ms < FadeMin) return '0;
    half  = fade_ms >> 1;
    phase = ShortW'(elapsed % fade_ms);
    if (phase < half) return LevelW'((32'd255 * phase) / half);
    scaled = (32'd255 * (phase - half)) / half;
    return LevelW'(32'd255 - scaled);
  endfunction

  function automatic light_t advance_timer(input pass_t p);
    light_t r;
    logic   rise;
    r        = '0;
    r.bright = FullBright;
    if (p.clear_edge) clear_waiting = 1'b1;
    if (p.macro_edge) macro_waiting = 1'b1;

    if (p.motion) begin
      seen_at = p.now;
      if (motion_at == '0 || (p.now - motion_at) > away_ms) due_at = p.now + interval_ms;
      motion_at = p.now;
    end

    rise          = p.clear_low && !clear_was_low;
    clear_was_low = p.clear_low;
    if ((clear_waiting || rise) && (p.now - clear_at) >= TimeBits'(press_gap_ms)) begin
      clear_waiting = 1'b0;
      clear_at      = p.now;
      due_at        = p.now + interval_ms;
    end

    rise          = p.macro_low && !macro_was_low;
    macro_was_low = p.macro_low;
    if ((macro_waiting || rise) && (p.now - macro_at) >= TimeBits'(press_gap_ms)) begin
      macro_waiting = 1'b0;
      macro_at      = p.now;
      r.send        = 1'b1;
    end

    if (seen_at != '0 && (p.now - seen_at) > away_ms) begin
      due_at = '0;
    end else if (due_at != '0 && p.now >= due_at) begin
      r.green  = fade_level(p.now - due_at);
      r.bright = FadeBright;
    end
    r.armed = due_at != '0;
    return r;
  endfunction

  function automatic pass_t pass_at(input logic [TimeBits-1:0] now, input logic motion,
                                    input logic clow, input logic cedge,
                                    input logic mlow, input logic medge);
    return {now, motion, clow, cedge, mlow, medge};
  endfunction

  task automatic write_reg(input cfg_reg_e idx, input logic [CfgDataW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
  endtask

  // Call only while idle; upper bits of the short registers carry noise.
  task automatic load_settings(input logic [TimeBits-1:0] interval, input logic [TimeBits-1:0] away,
                               input logic [ShortW-1:0] debounce, input logic [ShortW-1:0] fade);
    write_reg(CfgReminder, interval);
    write_reg(CfgAway, away);
    write_reg(CfgDebounce, {ShortW'($urandom()), debounce});
    write_reg(CfgFade, {ShortW'($urandom()), fade});
    cfg_we_i     <= 1'b0;
    interval_ms  = interval;
    away_ms      = away;
    press_gap_ms = debounce;
    fade_ms      = fade;
  endtask

  task automatic push_pass(input pass_t p);
    if (!calm && $urandom_range(99) < 28) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < 45);
    end
    in_valid_i    <= 1'b1;
    now_ms_i      <= p.now;
    motion_edge_i <= p.motion;
    clear_low_i   <= p.clear_low;
    clear_edge_i  <= p.clear_edge;
    macro_low_i   <= p.macro_low;
    macro_edge_i  <= p.macro_edge;
    do @(posedge clk_i); while (!in_ready_o);
    pending_lights.push_back(advance_timer(p));
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_lights.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Buttons hold their level for a while; edge flags mostly follow presses, sometimes noise.
  task automatic run_desk_day(input int unsigned count, input logic [TimeBits-1:0] span,
                              input int unsigned motion_pct);
    logic [TimeBits-1:0] step;
    int unsigned         pick;
    pass_t               p;
    p = '0;
    for (int unsigned n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 60) step = $urandom_range(span >> 4);
      else if (pick < 85) step = $urandom_range(span >> 1);
      else if (pick < 97) step = $urandom_range(span);
      else step = $urandom();
      desk_ms += step;
      if ($urandom_range(99) < 15) clear_held = !clear_held;
      if ($urandom_range(99) < 15) macro_held = !macro_held;
      p.now        = desk_ms;
      p.motion     = $urandom_range(99) < motion_pct;
      p.clear_edge = (clear_held && !p.clear_low) || ($urandom_range(99) < 4);
      p.clear_low  = clear_held;
      p.macro_edge = (macro_held && !p.macro_low) || ($urandom_range(99) < 4);
      p.macro_low  = macro_held;
      if ($urandom_range(199) == 0) wait_drained();
      push_pass(p);
    end
  endtask

  task automatic test_defaults();
    push_pass(pass_at(32'd0, 1, 0, 0, 0, 0));
    for (int unsigned t = 1000; t <= 1_200_000; t += (t == 1000) ? 199_000 : 200_000)
      push_pass(pass_at(t, 1, 0, 0, 0, 0));
    push_pass(pass_at(32'd1_201_625, 0, 0, 0, 0, 0));
    push_pass(pass_at(32'd1_202_250, 0, 0, 1, 0, 0));
    push_pass(pass_at(32'd1_202_300, 0, 0, 0, 1, 1));
    push_pass(pass_at(32'd1_202_350, 0, 0, 0, 1, 1));
    push_pass(pass_at(32'd1_202_600, 0, 0, 0, 0, 0));
    push_pass(pass_at(32'd1_202_700, 0, 1, 0, 0, 0));
    push_pass(pass_at(32'd1_500_000, 0, 0, 0, 0, 0));
    push_pass(pass_at(32'hFFFF_FFFF, 1, 1, 1, 1, 1));
    wait_drained();
  endtask

  task automatic test_wrap_zero();
    load_settings(32'd100, 32'd1000, 16'd0, 16'd1);
    push_pass(pass_at(32'hFFFF_FF9C, 1, 0, 0, 0, 0));
    push_pass(pass_at(32'h0000_0010, 1, 0, 0, 0, 0));
    push_pass(pass_at(32'h0000_0020, 0, 1, 0, 0, 0));
    push_pass(pass_at(32'h0000_0084, 0, 1, 0, 0, 0));
    push_pass(pass_at(32'h0000_0090, 0, 0, 0, 0, 1));
    push_pass(pass_at(32'h0000_0090, 0, 0, 0, 0, 1));
    wait_drained();
  endtask

  task automatic test_short_timers();
    load_settings(32'd300, 32'd1000, 16'd50, 16'd400);
    desk_ms = $urandom();
    run_desk_day(400, 32'd1500, 30);
    wait_drained();
  endtask

  task automatic test_extreme_settings();
    load_settings(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
    run_desk_day(150, 32'hFFFF_FFFF, 40);
    wait_drained();
  endtask

  task automatic test_minimum_settings();
    load_settings(32'd1, 32'd0, 16'd0, FadeMin);
    run_desk_day(200, 32'd8, 30);
    wait_drained();
  endtask

  task automatic test_zero_fade();
    load_settings(32'd20, 32'd200, 16'd10, 16'd0);
    run_desk_day(150, 32'd300, 40);
    wait_drained();
  endtask

  task automatic test_clock_wrap();
    load_settings(32'd500, 32'd3000, 16'd120, 16'd777);
    desk_ms = 32'hFFFF_F000;
    calm    = 1'b1;
    run_desk_day(400, 32'd4000, 35);
    wait_drained();
    calm    = 1'b0;
  endtask

  task automatic test_random_settings();
    logic [TimeBits-1:0] interval;
    logic [TimeBits-1:0] away;
    for (int unsigned k = 0; k < 4; k++) begin
      interval = $urandom_range(5000, 1);
      away     = $urandom_range(8000);
      load_settings(interval, away, ShortW'($urandom_range(400)), ShortW'($urandom_range(3000, 2)));
      desk_ms = $urandom();
      run_desk_day(100, interval + away + 32'd16, 30);
      wait_drained();
    end
  endtask

  task automatic compare_field(input string name, input logic [LevelW-1:0] exp,
                               input logic [LevelW-1:0] got);
    if (exp !== got) begin
      $display("%0t %s: expected %0d, actual %0d", $time, name, exp, got);
      faults++;
    end
  endtask

  always @(posedge clk_i) out_ready_i <= calm || ($urandom_range(99) >= 28);

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_lights.size() == 0) begin
        $display("%0t unexpected word: expected none, actual green %0d bright %0d send %0b armed %0b",
                 $time, green_level_o, pixel_brightness_o, send_macro_o, timer_armed_o);
        faults++;
      end else begin
        want_light = pending_lights.pop_front();
        compare_field("green_level", want_light.green, green_level_o);
        compare_field("pixel_brightness", want_light.bright, pixel_brightness_o);
        compare_field("send_macro", LevelW'(want_light.send), LevelW'(send_macro_o));
        compare_field("timer_armed", LevelW'(want_light.armed), LevelW'(timer_armed_o));
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("presence_reminder_timer: mismatch");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_defaults();
    test_wrap_zero();
    test_short_timers();
    test_extreme_settings();
    test_minimum_settings();
    test_zero_fade();
    test_clock_wrap();
    test_random_settings();
    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (faults == 0) begin
      $display("presence_reminder_timer: match");
    end else begin
      $display("presence_reminder_timer: mismatch");
    end
    $finish;
  end

endmodule
